### src/page_reader_writer_lock_table_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the page lock table
// Concurrent checks that vanish when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef PAGE_READER_WRITER_LOCK_TABLE_CORE_DEFINES_SVH
`define PAGE_READER_WRITER_LOCK_TABLE_CORE_DEFINES_SVH

`ifndef SYNTH

// consequent holds in the same cycle as the antecedent
`define PRWL_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prwl check failed");

// consequent holds in the cycle after the antecedent
`define PRWL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prwl check failed");

`else

`define PRWL_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define PRWL_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

### src/prwl_pkg.sv
// ---------------------------------------------------------------------------
// prwl_pkg
// Sizes, codes, chain records and helpers shared by the lock table modules.
// ---------------------------------------------------------------------------
package prwl_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 8;
    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int PAGE_BITS  = 32;
    localparam int HOLD_BITS  = 8;

    // count codes
    localparam logic [COUNT_BITS-1:0] READER_CAP = COUNT_BITS'((1 << (COUNT_BITS - 1)) - 1);
    localparam logic [COUNT_BITS-1:0] CNT_ONE    = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] CNT_FREE   = '0;
    localparam logic [COUNT_BITS-1:0] CNT_WRITER = '1;

    // operation codes
    localparam logic [1:0] OP_SHARED  = 2'd0;
    localparam logic [1:0] OP_EXCL    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    // request record walking down the cell chain
    typedef struct packed {
        logic                  valid;
        logic [1:0]            op;
        logic [PAGE_BITS-1:0]  page;
        logic                  hit;
        logic [IDX_BITS-1:0]   hit_idx;
        logic [COUNT_BITS-1:0] hit_count;
        logic                  free_found;
        logic [IDX_BITS-1:0]   free_idx;
    } t_scan;

    // entry write broadcast to the cells
    typedef struct packed {
        logic                  valid;
        logic [IDX_BITS-1:0]   idx;
        logic                  used;
        logic [PAGE_BITS-1:0]  page;
        logic [COUNT_BITS-1:0] count;
    } t_upd;

    // result word
    typedef struct packed {
        logic [1:0]           status;
        logic [HOLD_BITS-1:0] holders;
    } t_result;

    // clamp a holder count into the 8-bit signed result field
    function automatic logic [HOLD_BITS-1:0] sat_holders(input logic [COUNT_BITS-1:0] c);
        logic [16:0] w;
        w = {{(17 - COUNT_BITS){c[COUNT_BITS-1]}}, c};
        if (!w[16] && (w > 17'd127)) begin
            return HOLD_BITS'(127);
        end
        return w[HOLD_BITS-1:0];
    endfunction

endpackage

### src/prwl_cell.sv
// ---------------------------------------------------------------------------
// prwl_cell
// One table entry: tag, holder count and used bit. Checks the passing
// request against its entry and hands the request on to the next cell.
// ---------------------------------------------------------------------------
module prwl_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [prwl_pkg::IDX_BITS-1:0]  i_index,
    input  prwl_pkg::t_scan                i_scan,
    input  prwl_pkg::t_upd                 i_upd,
    output prwl_pkg::t_scan                o_scan
);
    import prwl_pkg::*;

    logic                  r_used;
    logic [PAGE_BITS-1:0]  r_page;
    logic [COUNT_BITS-1:0] r_count;
    t_scan                 r_scan;
    t_scan                 n_scan;

    // note the first tag hit and the first free slot
    always_comb begin
        n_scan = i_scan;
        if (!i_scan.hit && r_used && (r_page == i_scan.page)) begin
            n_scan.hit       = 1'b1;
            n_scan.hit_idx   = i_index;
            n_scan.hit_count = r_count;
        end
        if (!i_scan.free_found && !r_used) begin
            n_scan.free_found = 1'b1;
            n_scan.free_idx   = i_index;
        end
    end

    // advance the request one cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.valid <= 1'b0;
        end else begin
            r_scan <= n_scan;
        end
    end

    // write the entry when the update targets this cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_upd.valid && (i_upd.idx == i_index)) begin
            r_used <= i_upd.used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.valid && (i_upd.idx == i_index)) begin
            r_page  <= i_upd.page;
            r_count <= i_upd.count;
        end
    end

    assign o_scan = r_scan;

endmodule

### src/prwl_resolve.sv
// ---------------------------------------------------------------------------
// prwl_resolve
// Turns the finished chain walk into an entry update and a result word.
// ---------------------------------------------------------------------------
module prwl_resolve (
    input  prwl_pkg::t_scan   i_scan,
    output prwl_pkg::t_upd    o_upd,
    output prwl_pkg::t_result o_result
);
    import prwl_pkg::*;

    logic                  slot_ok;
    logic [IDX_BITS-1:0]   slot;
    logic [COUNT_BITS-1:0] cnt;
    logic [COUNT_BITS-1:0] new_cnt;

    // pick the matched entry, else the lowest free slot with count zero
    always_comb begin
        slot_ok = i_scan.hit || i_scan.free_found;
        slot    = i_scan.hit ? i_scan.hit_idx : i_scan.free_idx;
        cnt     = i_scan.hit ? i_scan.hit_count : CNT_FREE;
    end

    // apply the lock rules
    always_comb begin
        new_cnt         = cnt;
        o_upd.valid     = 1'b0;
        o_upd.idx       = slot;
        o_upd.used      = 1'b1;
        o_upd.page      = i_scan.page;
        o_upd.count     = cnt;
        o_result.status = ST_OK;
        o_result.holders = '0;
        unique case (i_scan.op)
            OP_SHARED: begin
                if (!slot_ok) begin
                    o_result.status = ST_FULL;
                end else begin
                    if (cnt[COUNT_BITS-1] || (cnt == READER_CAP)) begin
                        o_result.status = ST_BUSY;
                    end else begin
                        new_cnt = cnt + CNT_ONE;
                    end
                    o_upd.valid      = i_scan.valid;
                    o_upd.count      = new_cnt;
                    o_result.holders = sat_holders(new_cnt);
                end
            end
            OP_EXCL: begin
                if (!slot_ok) begin
                    o_result.status = ST_FULL;
                end else begin
                    if (cnt != CNT_FREE) begin
                        o_result.status = ST_BUSY;
                    end else begin
                        new_cnt = CNT_WRITER;
                    end
                    o_upd.valid      = i_scan.valid;
                    o_upd.count      = new_cnt;
                    o_result.holders = sat_holders(new_cnt);
                end
            end
            OP_RELEASE: begin
                if (!i_scan.hit) begin
                    o_result.status = ST_UNKNOWN;
                end else if (!cnt[COUNT_BITS-1] && (cnt != CNT_FREE)) begin
                    new_cnt          = cnt - CNT_ONE;
                    o_upd.valid      = i_scan.valid;
                    o_upd.count      = new_cnt;
                    o_result.holders = sat_holders(new_cnt);
                end else begin
                    // writer or free count: drop the entry
                    o_upd.valid = i_scan.valid;
                    o_upd.used  = 1'b0;
                    o_upd.count = CNT_FREE;
                end
            end
            default: begin
                // unused operation: no change
            end
        endcase
    end

endmodule

### src/page_reader_writer_lock_table_core.sv
// ---------------------------------------------------------------------------
// page_reader_writer_lock_table_core
// Reader/writer lock table over 32-bit page numbers.
// ---------------------------------------------------------------------------
// One request word is handled at a time. The request walks a chain of
// ENTRIES cells, one cell per clock, each comparing it against its own entry;
// the cycle after it leaves the last cell the entry is written and the result
// word is registered. The result word is therefore presented once the request
// has passed through every cell of the chain, and the next request is taken
// the cycle after the result has been taken, so one request must be through
// before the next one is taken.
module page_reader_writer_lock_table_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_operation,
    input  logic [prwl_pkg::PAGE_BITS-1:0]  i_page,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [1:0]                      o_status,
    output logic signed [prwl_pkg::HOLD_BITS-1:0] o_holders
);
    import prwl_pkg::*;

    `include "page_reader_writer_lock_table_core_defines.svh"

    logic            r_busy;
    logic            w_in_take;
    logic            w_out_take;
    t_scan           w_chain [0:ENTRIES];
    logic [ENTRIES-1:0] w_chain_valid;
    t_upd            w_upd;
    t_result         w_result;

    assign w_in_take  = i_valid && !o_stall;
    assign w_out_take = o_valid && !i_stall;
    assign o_stall    = r_busy;

    // hold busy from the request until its result word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_in_take) begin
            r_busy <= 1'b1;
        end else if (w_out_take) begin
            r_busy <= 1'b0;
        end
    end

    // inject the request at the head of the chain
    always_comb begin
        w_chain[0]            = '0;
        w_chain[0].valid      = w_in_take;
        w_chain[0].op         = i_operation;
        w_chain[0].page       = i_page;
    end

    // cell chain
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        prwl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_BITS'(g)),
            .i_scan  (w_chain[g]),
            .i_upd   (w_upd),
            .o_scan  (w_chain[g+1])
        );
        assign w_chain_valid[g] = w_chain[g+1].valid;
    end

    prwl_resolve u_resolve (
        .i_scan   (w_chain[ENTRIES]),
        .o_upd    (w_upd),
        .o_result (w_result)
    );

    // register the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_chain[ENTRIES].valid) begin
            o_valid <= 1'b1;
        end else if (w_out_take) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_chain[ENTRIES].valid) begin
            o_status  <= w_result.status;
            o_holders <= w_result.holders;
        end
    end

    // checks
    `PRWL_ASSERT_NOW(a_one_in_chain, i_clk, i_rst_n, 1'b1, $onehot0(w_chain_valid))
    `PRWL_ASSERT_NOW(a_result_busy, i_clk, i_rst_n, o_valid, r_busy)
    `PRWL_ASSERT_NOW(a_tail_no_result, i_clk, i_rst_n, w_chain[ENTRIES].valid, !o_valid)
    `PRWL_ASSERT_NEXT(a_take_stalls, i_clk, i_rst_n, w_in_take, o_stall)
    `PRWL_ASSERT_NEXT(a_result_drops, i_clk, i_rst_n, w_out_take, !o_valid)

endmodule
